/* rtl/npc_pkg.sv */
// Shared types, constants and helpers of the nearest path point coverage core.
// Used by every module of the block but npc_ram; depends on nothing.
package npc_pkg;

    // Path storage and coordinate sizes.
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 20;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int SUM_W      = SQ_W + 2;

    // Fixed field widths of the channels and registers.
    localparam int OP_W       = 3;
    localparam int DIST_W     = 44;
    localparam int RATIO_CFG_W = 17;
    localparam int AGE_W      = 16;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_CNT_W  = 11;
    localparam int CMP_W      = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam int RATIO_W    = CNT_W + RATIO_CFG_W;
    localparam int IN_DATA_W  = ((OP_W + 3 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 104;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam logic [1:0] REG_MIN_RATIO = 2'd0;
    localparam logic [1:0] REG_MAX_REACH = 2'd1;
    localparam logic [1:0] REG_MAX_AGE   = 2'd2;

    // Opcodes of the input channel.
    localparam logic [OP_W-1:0] OP_POINT  = 3'd0;
    localparam logic [OP_W-1:0] OP_TARGET = 3'd1;
    localparam logic [OP_W-1:0] OP_TRACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_GATE   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    // Age counter slots.
    localparam logic [1:0] SRC_PATH   = 2'd0;
    localparam logic [1:0] SRC_TARGET = 2'd1;
    localparam logic [1:0] SRC_TRACK  = 2'd2;
    localparam logic [1:0] SRC_GATE   = 2'd3;

    typedef enum logic [2:0] {
        K_POINT, K_TARGET, K_TRACK, K_GATE, K_TICK, K_NOP
    } kind_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } point_t;

    // One queued item after classification.
    typedef struct packed {
        kind_t  kind;
        point_t pt;
        logic   last;
        logic   flag;
    } entry_t;

    // Back end status seen by the checks at the top level.
    typedef struct packed {
        logic             init;
        logic             pop;
        logic [CNT_W-1:0] covered;
        logic [CNT_W-1:0] committed;
    } dbg_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_EXEC, ST_COMMIT, ST_CLEAR,
        ST_SCAN, ST_MARK_RD, ST_MARK_WR, ST_EMIT
    } st_t;

    function automatic kind_t classify(input logic [OP_W-1:0] op);
        kind_t k;
        unique case (op)
            OP_POINT:  k = K_POINT;
            OP_TARGET: k = K_TARGET;
            OP_TRACK:  k = K_TRACK;
            OP_GATE:   k = K_GATE;
            OP_TICK:   k = K_TICK;
            default:   k = K_NOP;
        endcase
        return k;
    endfunction

endpackage

/* rtl/npc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Standalone; used for the path store and the coverage bitmap.
module npc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/npc_front.sv */
// Front end: accepts input items, classifies the opcode and queues them.
// Depends on npc_pkg.
module npc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode[2:0], coord_x[22:3], coord_y[42:23], coord_z[62:43], zero pad
    input  logic [npc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    // flag_value
    input  logic                          s_tuser,
    input  logic                          pop,
    output npc_pkg::entry_t               head,
    output logic                          head_valid
);

    localparam int CW = npc_pkg::COORD_BITS;
    localparam int OW = npc_pkg::OP_W;

    npc_pkg::entry_t ent_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    npc_pkg::entry_t incoming;
    logic            push;

    // Decode the incoming item.
    always_comb begin
        incoming.kind = npc_pkg::classify(s_tdata[OW-1:0]);
        incoming.pt.x = s_tdata[OW +: CW];
        incoming.pt.y = s_tdata[OW + CW +: CW];
        incoming.pt.z = s_tdata[OW + 2*CW +: CW];
        incoming.last = s_tlast;
        incoming.flag = s_tuser;
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = ent_reg[rd_ptr_reg];

    // Two-entry queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= incoming;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/npc_back.sv */
// Back end: executes queued items, scans the path and builds each result item.
// Depends on npc_pkg and npc_ram.
module npc_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  npc_pkg::entry_t                     head,
    input  logic                                head_valid,
    output logic                                pop,
    input  logic [npc_pkg::RATIO_CFG_W-1:0]     min_ratio,
    input  logic [npc_pkg::DIST_W-1:0]          max_reach,
    input  logic [npc_pkg::AGE_W-1:0]           max_age,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [npc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output npc_pkg::dbg_t                       dbg
);

    localparam int IW  = npc_pkg::IDX_W;
    localparam int CNW = npc_pkg::CNT_W;
    localparam int AW  = npc_pkg::AGE_W;

    npc_pkg::st_t    state_reg, state_next;
    npc_pkg::entry_t item_reg;

    logic [CNW-1:0] load_pos_reg, committed_reg, covered_reg;
    logic [15:0]    targets_reg;
    npc_pkg::point_t first_reg, last_reg, sig_first_reg, sig_last_reg;
    logic           sig_valid_reg;
    logic [CNW-1:0] sig_count_reg;
    logic [AW-1:0]  ages_reg [4];
    logic [3:0]     seen_reg;
    logic [1:0]     flags_reg;
    logic [npc_pkg::DIST_W-1:0] last_dist_reg;
    logic [IW-1:0]  last_idx_reg;
    logic           last_hit_reg;
    logic [IW-1:0]  clr_cnt_reg;

    // Scan pipeline.
    logic [CNW-1:0] issue_reg;
    logic           p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [IW-1:0]  p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic signed [npc_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [npc_pkg::SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [npc_pkg::SUM_W-1:0] best_reg;
    logic [IW-1:0]  best_idx_reg;

    logic                             m_tvalid_reg;
    logic [npc_pkg::OUT_DATA_W-1:0]   m_tdata_reg;

    // RAM controls.
    logic            path_we, path_re;
    logic [IW-1:0]   path_waddr, path_raddr;
    logic [3*npc_pkg::COORD_BITS-1:0] path_rdata;
    npc_pkg::point_t rd_pt;
    logic            cov_we, cov_re, cov_wdata;
    logic [IW-1:0]   cov_waddr;
    logic [0:0]      cov_rdata;

    logic            issue, scan_done, clr_done, keep_point, sig_differs, hit, load_out;
    logic [npc_pkg::SUM_W-1:0] sum;
    logic signed [npc_pkg::SQ_W-1:0] prx, pry, prz;
    logic [3:0]      fresh;
    logic            ratio_ok, trk_ok, gte_ok, ready;
    logic [CNW-1:0]  n_next;

    npc_ram #(.WIDTH(3*npc_pkg::COORD_BITS), .DEPTH(npc_pkg::MAX_POINTS)) u_path_ram (
        .aclk(aclk), .we(path_we), .waddr(path_waddr), .wdata(item_reg.pt),
        .re(path_re), .raddr(path_raddr), .rdata(path_rdata)
    );

    npc_ram #(.WIDTH(1), .DEPTH(npc_pkg::MAX_POINTS)) u_cov_ram (
        .aclk(aclk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
        .re(cov_re), .raddr(best_idx_reg), .rdata(cov_rdata)
    );

    // Shared conditions.
    assign rd_pt       = npc_pkg::point_t'(path_rdata);
    assign keep_point  = (load_pos_reg < CNW'(npc_pkg::MAX_POINTS));
    assign issue       = (state_reg == npc_pkg::ST_SCAN) && (issue_reg < committed_reg);
    assign scan_done   = (issue_reg == committed_reg) && !p1_vld_reg && !p2_vld_reg
                         && !p3_vld_reg;
    assign clr_done    = (clr_cnt_reg == IW'(npc_pkg::MAX_POINTS - 1));
    assign sig_differs = !sig_valid_reg || (sig_count_reg != load_pos_reg)
                         || (sig_first_reg != first_reg) || (sig_last_reg != last_reg);
    assign hit         = npc_pkg::CMP_W'(best_reg) <= npc_pkg::CMP_W'(max_reach);
    assign load_out    = (state_reg == npc_pkg::ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign sum = npc_pkg::SUM_W'(sqx_reg) + npc_pkg::SUM_W'(sqy_reg)
               + npc_pkg::SUM_W'(sqz_reg);
    assign prx = dx_reg * dx_reg;
    assign pry = dy_reg * dy_reg;
    assign prz = dz_reg * dz_reg;
    assign n_next = load_pos_reg + CNW'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            npc_pkg::ST_INIT: begin
                if (clr_done) state_next = npc_pkg::ST_IDLE;
            end
            npc_pkg::ST_IDLE: begin
                if (head_valid) state_next = npc_pkg::ST_EXEC;
            end
            npc_pkg::ST_EXEC: begin
                priority if (item_reg.kind == npc_pkg::K_POINT && item_reg.last) begin
                    state_next = npc_pkg::ST_COMMIT;
                end else if (item_reg.kind == npc_pkg::K_TARGET
                             && committed_reg != '0) begin
                    state_next = npc_pkg::ST_SCAN;
                end else begin
                    state_next = npc_pkg::ST_EMIT;
                end
            end
            npc_pkg::ST_COMMIT: begin
                state_next = sig_differs ? npc_pkg::ST_CLEAR : npc_pkg::ST_EMIT;
            end
            npc_pkg::ST_CLEAR: begin
                if (clr_done) state_next = npc_pkg::ST_EMIT;
            end
            npc_pkg::ST_SCAN: begin
                if (scan_done) state_next = npc_pkg::ST_MARK_RD;
            end
            npc_pkg::ST_MARK_RD: state_next = npc_pkg::ST_MARK_WR;
            npc_pkg::ST_MARK_WR: state_next = npc_pkg::ST_EMIT;
            npc_pkg::ST_EMIT: begin
                if (load_out) state_next = npc_pkg::ST_IDLE;
            end
            default: state_next = npc_pkg::ST_INIT;
        endcase
    end

    // Control outputs of the state machine.
    always_comb begin
        pop        = (state_reg == npc_pkg::ST_IDLE) && head_valid;
        path_we    = (state_reg == npc_pkg::ST_EXEC) && (item_reg.kind == npc_pkg::K_POINT)
                     && keep_point;
        path_waddr = load_pos_reg[IW-1:0];
        path_re    = issue;
        path_raddr = issue_reg[IW-1:0];
        cov_re     = (state_reg == npc_pkg::ST_MARK_RD);
        cov_we     = 1'b0;
        cov_waddr  = clr_cnt_reg;
        cov_wdata  = 1'b0;
        unique case (state_reg)
            npc_pkg::ST_INIT, npc_pkg::ST_CLEAR: cov_we = 1'b1;
            npc_pkg::ST_MARK_WR: begin
                cov_we    = last_hit_reg && !cov_rdata[0];
                cov_waddr = best_idx_reg;
                cov_wdata = 1'b1;
            end
            default: cov_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= npc_pkg::ST_INIT;
        else          state_reg <= state_next;
    end

    // Item holding register and path load bookkeeping.
    always_ff @(posedge aclk) begin
        if (pop) item_reg <= head;
        if (path_we) begin
            last_reg <= item_reg.pt;
            if (load_pos_reg == '0) first_reg <= item_reg.pt;
        end
    end

    // Sweep counter for clearing the coverage bitmap.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (state_reg == npc_pkg::ST_INIT || state_reg == npc_pkg::ST_CLEAR) begin
            clr_cnt_reg <= clr_done ? '0 : clr_cnt_reg + IW'(1);
        end
    end

    // Path, coverage and target counters plus the path signature.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg  <= '0;
            committed_reg <= '0;
            covered_reg   <= '0;
            targets_reg   <= '0;
            sig_valid_reg <= 1'b0;
            sig_count_reg <= '0;
            sig_first_reg <= '0;
            sig_last_reg  <= '0;
        end else begin
            if (path_we) load_pos_reg <= n_next;
            if (state_reg == npc_pkg::ST_COMMIT) begin
                committed_reg <= load_pos_reg;
                load_pos_reg  <= '0;
                if (sig_differs) begin
                    covered_reg   <= '0;
                    targets_reg   <= '0;
                    sig_valid_reg <= 1'b1;
                    sig_count_reg <= load_pos_reg;
                    sig_first_reg <= first_reg;
                    sig_last_reg  <= last_reg;
                end
            end
            if (state_reg == npc_pkg::ST_EXEC && item_reg.kind == npc_pkg::K_TARGET
                && targets_reg != 16'hFFFF) begin
                targets_reg <= targets_reg + 16'd1;
            end
            if (cov_we && cov_wdata) covered_reg <= covered_reg + CNW'(1);
        end
    end

    // Source ages, seen marks and status flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 4; s++) ages_reg[s] <= '0;
            seen_reg  <= '0;
            flags_reg <= '0;
        end else if (state_reg == npc_pkg::ST_COMMIT) begin
            seen_reg[npc_pkg::SRC_PATH] <= 1'b1;
            ages_reg[npc_pkg::SRC_PATH] <= '0;
        end else if (state_reg == npc_pkg::ST_EXEC) begin
            unique case (item_reg.kind)
                npc_pkg::K_TARGET: begin
                    seen_reg[npc_pkg::SRC_TARGET] <= 1'b1;
                    ages_reg[npc_pkg::SRC_TARGET] <= '0;
                end
                npc_pkg::K_TRACK: begin
                    seen_reg[npc_pkg::SRC_TRACK] <= 1'b1;
                    ages_reg[npc_pkg::SRC_TRACK] <= '0;
                    flags_reg[0] <= item_reg.flag;
                end
                npc_pkg::K_GATE: begin
                    seen_reg[npc_pkg::SRC_GATE] <= 1'b1;
                    ages_reg[npc_pkg::SRC_GATE] <= '0;
                    flags_reg[1] <= item_reg.flag;
                end
                npc_pkg::K_TICK: begin
                    for (int s = 0; s < 4; s++) begin
                        if (ages_reg[s] != '1) ages_reg[s] <= ages_reg[s] + AW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Scan pipeline: read, difference, square, then sum and compare.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg  <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else begin
            if (state_reg == npc_pkg::ST_EXEC) issue_reg <= '0;
            else if (issue)                    issue_reg <= issue_reg + CNW'(1);
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg <= issue_reg[IW-1:0];
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        dx_reg <= npc_pkg::DIFF_W'(rd_pt.x) - npc_pkg::DIFF_W'(item_reg.pt.x);
        dy_reg <= npc_pkg::DIFF_W'(rd_pt.y) - npc_pkg::DIFF_W'(item_reg.pt.y);
        dz_reg <= npc_pkg::DIFF_W'(rd_pt.z) - npc_pkg::DIFF_W'(item_reg.pt.z);
        sqx_reg <= prx;
        sqy_reg <= pry;
        sqz_reg <= prz;
        // First point always wins; a later one only when strictly closer.
        if (p3_vld_reg && (p3_idx_reg == '0 || sum < best_reg)) begin
            best_reg     <= sum;
            best_idx_reg <= p3_idx_reg;
        end
    end

    // Latest scan result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_dist_reg <= '1;
            last_idx_reg  <= '0;
            last_hit_reg  <= 1'b0;
        end else if (state_reg == npc_pkg::ST_MARK_RD) begin
            last_dist_reg <= npc_pkg::DIST_W'(best_reg);
            last_idx_reg  <= best_idx_reg;
            last_hit_reg  <= hit;
        end
    end

    // Status flags of the result.
    always_comb begin
        for (int s = 0; s < 4; s++) fresh[s] = seen_reg[s] && (ages_reg[s] <= max_age);
        trk_ok   = fresh[npc_pkg::SRC_TRACK] && flags_reg[0];
        gte_ok   = fresh[npc_pkg::SRC_GATE] && flags_reg[1];
        ratio_ok = (npc_pkg::RATIO_W'({covered_reg, 16'h0000}))
                   >= (npc_pkg::RATIO_W'(min_ratio) * npc_pkg::RATIO_W'(committed_reg));
        ready    = fresh[npc_pkg::SRC_PATH] && fresh[npc_pkg::SRC_TARGET] && trk_ok
                   && gte_ok && ratio_ok;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {6'b0, ready, gte_ok, trk_ok, fresh[npc_pkg::SRC_TARGET],
                            fresh[npc_pkg::SRC_PATH], targets_reg,
                            npc_pkg::OUT_CNT_W'(committed_reg),
                            npc_pkg::OUT_CNT_W'(covered_reg), last_hit_reg,
                            last_dist_reg, npc_pkg::OUT_IDX_W'(last_idx_reg)};
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign dbg.init      = (state_reg == npc_pkg::ST_INIT);
    assign dbg.pop       = pop;
    assign dbg.covered   = covered_reg;
    assign dbg.committed = committed_reg;

endmodule

/* rtl/nearest_path_point_coverage_core.sv */
// Usage of the nearest path point coverage core.
// Input channel s_*: one item per handshake carrying an opcode (path point, target,
// tracking status, gate status, tick), a 3-D point, tlast to commit a path load and
// tuser for the status flag value. Result channel m_*: exactly one result item per
// input item, in order, with nearest index and distance, coverage counts, ages-based
// freshness flags and the coverage readiness flag.
// Configuration: APB registers at byte 0 (min ratio), 8 (max reach squared), 16 (max age).
// Timing: the back end works on one item at a time. A status, tick, unknown, plain point
// item or a target with no committed path goes from idle through execute to the emit
// state, and a committing point also passes the commit state. A target scans the
// committed points through the path memory read port, which delivers one stored
// point per cycle to the 3-stage distance pipeline, then reads and writes the coverage
// memory to mark the nearest point when in reach. A commit with a new path signature
// also runs the sweep that clears the coverage memory.
// Reset: synchronous, active low; afterwards a sweep clears the coverage memory, while
// the two-entry input queue still accepts up to two items.
// When the receiver stalls, the result stays in the output register and the queue
// keeps taking items until it holds two.
// Depends on npc_pkg, npc_front, npc_back and npc_ram.
module nearest_path_point_coverage_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[2:0], coord_x[22:3], coord_y[42:23], coord_z[62:43], zero pad
    input  logic [npc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    // flag_value
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // nearest_index[9:0], nearest_dist_sq[53:10], within_reach[54], covered_count[65:55],
    // path_size[76:66], target_count[92:77], path_live[93], target_live[94],
    // tracking_ok[95], gate_ok[96], cov_ready[97], zero pad
    output logic [npc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [npc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [npc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [npc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [npc_pkg::RATIO_CFG_W-1:0] min_ratio_reg;
    logic [npc_pkg::DIST_W-1:0]      max_reach_reg;
    logic [npc_pkg::AGE_W-1:0]       max_age_reg;
    logic [1:0]                      reg_sel;
    logic                            cfg_wr;
    npc_pkg::entry_t                 head;
    logic                            head_valid;
    logic                            pop;
    npc_pkg::dbg_t                   dbg;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_ratio_reg <= 17'd52429;
            max_reach_reg <= 44'd4000000;
            max_age_reg   <= 16'd30;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                npc_pkg::REG_MIN_RATIO: min_ratio_reg <= pwdata[npc_pkg::RATIO_CFG_W-1:0];
                npc_pkg::REG_MAX_REACH: max_reach_reg <= pwdata[npc_pkg::DIST_W-1:0];
                npc_pkg::REG_MAX_AGE:   max_age_reg   <= pwdata[npc_pkg::AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_sel)
            npc_pkg::REG_MIN_RATIO: prdata = npc_pkg::APB_DATA_W'(min_ratio_reg);
            npc_pkg::REG_MAX_REACH: prdata = npc_pkg::APB_DATA_W'(max_reach_reg);
            npc_pkg::REG_MAX_AGE:   prdata = npc_pkg::APB_DATA_W'(max_age_reg);
            default:                prdata = '0;
        endcase
    end

    npc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .pop(pop), .head(head), .head_valid(head_valid)
    );

    npc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head(head), .head_valid(head_valid), .pop(pop),
        .min_ratio(min_ratio_reg), .max_reach(max_reach_reg), .max_age(max_age_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .dbg(dbg)
    );

`ifndef SYNTHESIS
    // Coverage never counts more points than the committed path holds.
    a_cov_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dbg.covered <= dbg.committed)
        else $error("covered count exceeds path points");

    // No item is taken from the queue during the reset clearing sweep.
    a_no_pop_init: assert property (@(posedge aclk) disable iff (!aresetn)
        dbg.init |-> !dbg.pop)
        else $error("item taken during clearing sweep");

    // The back end only takes an item that the queue holds.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        dbg.pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

/* tb/sv/nearest_path_point_coverage_core_tb.sv */
// Testbench for nearest_path_point_coverage_core: drives path, target, status, tick and
// unknown items, predicts every result with its own coverage model and checks the result stream.
// Depends on npc_pkg and the core RTL.
`timescale 1ns / 100ps

module nearest_path_point_coverage_core_tb;

    localparam int  AGE_SAT       = 65535;
    localparam int  TARGETS_SAT   = 65535;
    localparam int  DRAIN_CYCLES  = 1200;
    localparam int  HOLD_CYCLES   = 400;
    localparam logic [npc_pkg::OP_W-1:0] OP_TOP_CODE = 3'd7;
    localparam logic [npc_pkg::DIST_W-1:0] DIST_ALL_ONES = '1;
    localparam logic [npc_pkg::DIST_W-1:0] REACH_TOP     = 44'd13194139533312;
    localparam logic [npc_pkg::RATIO_CFG_W-1:0] RATIO_FULL = 17'd65536;
    localparam logic signed [npc_pkg::COORD_BITS-1:0] C_MIN  = -20'sd524288;
    localparam logic signed [npc_pkg::COORD_BITS-1:0] C_MAX  = 20'sd524287;
    localparam logic signed [npc_pkg::COORD_BITS-1:0] C_ZERO = 20'sd0;

    typedef logic signed [npc_pkg::COORD_BITS-1:0] coord_t;

    // Expected fields of one result item.
    typedef struct {
        logic [npc_pkg::OUT_IDX_W-1:0] idx;
        logic [npc_pkg::DIST_W-1:0]    sq_dist;
        logic                          reach;
        logic [npc_pkg::OUT_CNT_W-1:0] covered;
        logic [npc_pkg::OUT_CNT_W-1:0] points;
        logic [15:0]                   targets;
        logic                          pf, tf, tr, gt, ready;
    } status_t;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, s_tlast, s_tuser;
    logic [npc_pkg::IN_DATA_W-1:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [npc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic psel, penable, pwrite, pready;
    logic [npc_pkg::APB_ADDR_W-1:0] paddr;
    logic [npc_pkg::APB_DATA_W-1:0] pwdata, prdata;

    nearest_path_point_coverage_core dut (.*);

    // Clock with a 12 ns period.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Coverage model state.
    int pt_x[npc_pkg::MAX_POINTS], pt_y[npc_pkg::MAX_POINTS], pt_z[npc_pkg::MAX_POINTS];
    bit hit_map[npc_pkg::MAX_POINTS];
    int hit_total, path_len, load_pos, target_total;
    bit sig_ok;
    int sig_n, sig_first[3], sig_last[3];
    int src_age[4];
    bit src_seen[4];
    bit track_flag, gate_flag;
    logic [npc_pkg::DIST_W-1:0] near_dist;
    int near_idx;
    bit near_hit;
    logic [npc_pkg::RATIO_CFG_W-1:0] cfg_ratio;
    logic [npc_pkg::DIST_W-1:0]      cfg_reach;
    logic [npc_pkg::AGE_W-1:0]       cfg_age;

    status_t pending_status[$];
    int error_count, items_sent, results_seen, targets_hit, commits_sent;
    bit gaps_on, stalls_on;
    int rx_hold, rx_wait;

    function automatic bit src_fresh(int s);
        return src_seen[s] && src_age[s] <= int'(cfg_age);
    endfunction

    // Path commit: clears coverage when the count, first or last point changed.
    function automatic void commit_model();
        int n, li;
        n  = load_pos;
        li = (n > 0) ? n - 1 : 0;
        if (!sig_ok || sig_n != n || sig_first[0] != pt_x[0] || sig_first[1] != pt_y[0] ||
            sig_first[2] != pt_z[0] || sig_last[0] != pt_x[li] || sig_last[1] != pt_y[li] ||
            sig_last[2] != pt_z[li]) begin
            foreach (hit_map[i]) hit_map[i] = 0;
            hit_total    = 0;
            target_total = 0;
            sig_ok       = 1;
            sig_n        = n;
            sig_first    = '{pt_x[0], pt_y[0], pt_z[0]};
            sig_last     = '{pt_x[li], pt_y[li], pt_z[li]};
        end
        path_len    = n;
        load_pos    = 0;
        src_seen[0] = 1;
        src_age[0]  = 0;
    endfunction

    // Nearest search over the committed path, first index wins on ties.
    function automatic void scan_model(int tx, int ty, int tz);
        longint unsigned best, d;
        longint dx, dy, dz;
        int bi;
        best = 0;
        bi   = 0;
        if (path_len == 0) return;
        for (int i = 0; i < path_len; i++) begin
            dx = longint'(pt_x[i]) - tx;
            dy = longint'(pt_y[i]) - ty;
            dz = longint'(pt_z[i]) - tz;
            d  = dx * dx + dy * dy + dz * dz;
            if (i == 0 || d < best) begin
                best = d;
                bi   = i;
            end
        end
        near_dist = best[npc_pkg::DIST_W-1:0];
        near_idx  = bi;
        near_hit  = (best <= longint'(cfg_reach));
        if (near_hit) targets_hit++;
        if (near_hit && !hit_map[bi]) begin
            hit_map[bi] = 1;
            hit_total++;
        end
    endfunction

    // Applies one accepted item to the model and returns its expected status.
    function automatic status_t apply_item(logic [npc_pkg::OP_W-1:0] op, coord_t x,
                                           coord_t y, coord_t z, logic last, logic flag);
        status_t r;
        longint unsigned lhs, rhs;
        case (op)
            npc_pkg::OP_POINT: begin
                if (load_pos < npc_pkg::MAX_POINTS) begin
                    pt_x[load_pos] = x;
                    pt_y[load_pos] = y;
                    pt_z[load_pos] = z;
                    load_pos++;
                end
                if (last) commit_model();
            end
            npc_pkg::OP_TARGET: begin
                src_seen[1] = 1;
                src_age[1]  = 0;
                if (target_total < TARGETS_SAT) target_total++;
                scan_model(x, y, z);
            end
            npc_pkg::OP_TRACK: begin
                src_seen[2] = 1;
                src_age[2]  = 0;
                track_flag  = flag;
            end
            npc_pkg::OP_GATE: begin
                src_seen[3] = 1;
                src_age[3]  = 0;
                gate_flag   = flag;
            end
            npc_pkg::OP_TICK: begin
                foreach (src_age[s]) if (src_age[s] < AGE_SAT) src_age[s]++;
            end
            default: ;
        endcase
        lhs       = longint'(hit_total) * 65536;
        rhs       = longint'(cfg_ratio) * longint'(path_len);
        r.idx     = near_idx[npc_pkg::OUT_IDX_W-1:0];
        r.sq_dist = near_dist;
        r.reach   = near_hit;
        r.covered = hit_total[npc_pkg::OUT_CNT_W-1:0];
        r.points  = path_len[npc_pkg::OUT_CNT_W-1:0];
        r.targets = target_total[15:0];
        r.pf      = src_fresh(0);
        r.tf      = src_fresh(1);
        r.tr      = src_fresh(2) && track_flag;
        r.gt      = src_fresh(3) && gate_flag;
        r.ready   = r.pf && r.tf && r.tr && r.gt && (lhs >= rhs);
        return r;
    endfunction

    // Sends one item, after a random gap when gaps are on, and records its expected status.
    task automatic send_item(logic [npc_pkg::OP_W-1:0] op, coord_t x, coord_t y, coord_t z,
                             logic last, logic flag);
        int gap;
        gap = gaps_on ? $urandom_range(12, 0) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tdata  <= {1'b0, z, y, x, op};
        s_tlast  <= last;
        s_tuser  <= flag;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(apply_item(op, x, y, z, last, flag));
        items_sent++;
        if (op == npc_pkg::OP_POINT && last) commits_sent++;
    endtask

    task automatic send_point(coord_t x, coord_t y, coord_t z, logic last);
        send_item(npc_pkg::OP_POINT, x, y, z, last, 1'b0);
    endtask

    function automatic coord_t rnd_coord();
        return coord_t'($urandom());
    endfunction

    function automatic coord_t near_coord(int c, int spread);
        return coord_t'(c + $urandom_range(2 * spread, 0) - spread);
    endfunction

    // Withdraws the offered item, then waits until every result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_status.size() > 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Two-phase register write, only while no result is outstanding.
    task automatic write_reg(logic [1:0] idx, logic [npc_pkg::APB_DATA_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            npc_pkg::REG_MIN_RATIO: cfg_ratio = value[npc_pkg::RATIO_CFG_W-1:0];
            npc_pkg::REG_MAX_REACH: cfg_reach = value[npc_pkg::DIST_W-1:0];
            npc_pkg::REG_MAX_AGE:   cfg_age   = value[npc_pkg::AGE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [npc_pkg::RATIO_CFG_W-1:0] ratio,
                              logic [npc_pkg::DIST_W-1:0] reach,
                              logic [npc_pkg::AGE_W-1:0] age);
        write_reg(npc_pkg::REG_MIN_RATIO, npc_pkg::APB_DATA_W'(ratio));
        write_reg(npc_pkg::REG_MAX_REACH, npc_pkg::APB_DATA_W'(reach));
        write_reg(npc_pkg::REG_MAX_AGE, npc_pkg::APB_DATA_W'(age));
    endtask

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        status_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_status.size() == 0) begin
                $error("result item with no expectation pending");
                error_count++;
            end else begin
                e = pending_status.pop_front();
                check_field("nearest_index", e.idx, m_tdata[9:0]);
                check_field("nearest_dist_sq", e.sq_dist, m_tdata[53:10]);
                check_field("within_reach", e.reach, m_tdata[54]);
                check_field("covered_count", e.covered, m_tdata[65:55]);
                check_field("path_size", e.points, m_tdata[76:66]);
                check_field("target_count", e.targets, m_tdata[92:77]);
                check_field("path_live", e.pf, m_tdata[93]);
                check_field("target_live", e.tf, m_tdata[94]);
                check_field("tracking_ok", e.tr, m_tdata[95]);
                check_field("gate_ok", e.gt, m_tdata[96]);
                check_field("cov_ready", e.ready, m_tdata[97]);
            end
            rx_wait <= stalls_on ? $urandom_range(12, 0) : 0;
        end
    end

    // Receiver readiness: long hold-offs first, then per-item stalls.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Extremes, every opcode, ties, reloads and unknown opcodes.
    task automatic test_directed();
        gaps_on   = 1;
        stalls_on = 1;
        set_config(17'd52429, 44'd4000000, 16'd30);
        send_item(npc_pkg::OP_TICK, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0);
        send_item(npc_pkg::OP_TARGET, C_MIN, C_MAX, C_MIN, 1'b0, 1'b1);
        for (logic [npc_pkg::OP_W-1:0] op = npc_pkg::OP_TICK + 3'd1;
             op <= OP_TOP_CODE && op != 3'd0; op++)
            send_item(op, rnd_coord(), rnd_coord(), rnd_coord(), 1'b1, 1'b1);
        send_item(npc_pkg::OP_TRACK, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1);
        send_item(npc_pkg::OP_GATE, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1);
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(C_MAX, C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(C_ZERO, C_ZERO, C_ZERO, 1'b1);
        send_item(npc_pkg::OP_TARGET, C_MIN, C_MIN, C_MIN, 1'b0, 1'b0);
        send_item(npc_pkg::OP_TARGET, C_MAX, C_MAX, C_MAX, 1'b0, 1'b0);
        send_item(npc_pkg::OP_TARGET, C_MAX, C_MIN, C_MAX, 1'b0, 1'b0);
        send_item(npc_pkg::OP_TARGET, 20'sd10, -20'sd10, 20'sd5, 1'b0, 1'b0);
        // Same count, first and last point: coverage survives the reload.
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(20'sd77, 20'sd77, 20'sd77, 1'b0);
        send_point(20'sd1, 20'sd2, 20'sd3, 1'b0);
        send_point(C_ZERO, C_ZERO, C_ZERO, 1'b1);
        send_item(npc_pkg::OP_TARGET, 20'sd70, 20'sd70, 20'sd70, 1'b0, 1'b0);
        // Different count and last point: coverage clears.
        send_point(C_MIN, C_MIN, C_MIN, 1'b0);
        send_point(20'sd5, C_ZERO, C_ZERO, 1'b1);
        send_item(npc_pkg::OP_TRACK, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0);
        send_item(npc_pkg::OP_GATE, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0);
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        gaps_on = 0;
        rx_hold = HOLD_CYCLES;
        repeat (20) send_item(npc_pkg::OP_TICK, C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0);
        wait_drained();
    endtask

    // Random traffic: mostly well-formed path loads with targets near the path.
    task automatic test_random(int count);
        int stop, choice, n, k, cx, cy, cz;
        stop = items_sent + count;
        cx   = 0;
        cy   = 0;
        cz   = 0;
        while (items_sent < stop) begin
            choice = $urandom_range(99, 0);
            if (choice < 6) begin
                k = $urandom_range(int'(OP_TOP_CODE), 0);
                send_item(k[npc_pkg::OP_W-1:0], rnd_coord(), rnd_coord(), rnd_coord(),
                          1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end else if (choice < 20) begin
                n = $urandom_range(12, 1);
                if (sig_ok && $urandom_range(3, 0) == 0) begin
                    // Reload with the old signature and new interior points.
                    for (int i = 0; i < sig_n; i++)
                        if (i == 0)
                            send_point(coord_t'(sig_first[0]), coord_t'(sig_first[1]),
                                       coord_t'(sig_first[2]), sig_n == 1);
                        else if (i == sig_n - 1)
                            send_point(coord_t'(sig_last[0]), coord_t'(sig_last[1]),
                                       coord_t'(sig_last[2]), 1'b1);
                        else
                            send_point(near_coord(cx, 3000), near_coord(cy, 3000),
                                       near_coord(cz, 3000), 1'b0);
                end else begin
                    cx = int'(rnd_coord());
                    cy = int'(rnd_coord());
                    cz = int'(rnd_coord());
                    for (int i = 0; i < n; i++)
                        send_point(near_coord(cx, 6000), near_coord(cy, 6000),
                                   near_coord(cz, 6000), i == n - 1);
                end
            end else if (choice < 62) begin
                if (path_len > 0) begin
                    k = $urandom_range(path_len - 1, 0);
                    send_item(npc_pkg::OP_TARGET, near_coord(pt_x[k], 1500),
                              near_coord(pt_y[k], 1500), near_coord(pt_z[k], 1500), 1'b0,
                              1'($urandom_range(1, 0)));
                end else begin
                    send_item(npc_pkg::OP_TARGET, rnd_coord(), rnd_coord(), rnd_coord(),
                              1'b0, 1'b0);
                end
            end else if (choice < 80) begin
                send_item($urandom_range(1, 0) ? npc_pkg::OP_TRACK : npc_pkg::OP_GATE,
                          rnd_coord(), C_ZERO, C_ZERO, 1'($urandom_range(1, 0)),
                          $urandom_range(4, 0) != 0);
            end else begin
                send_item(npc_pkg::OP_TICK, rnd_coord(), rnd_coord(), C_ZERO,
                          1'($urandom_range(1, 0)), 1'b0);
            end
            // Now and then toggles the sender gaps and picks the receiver stalls at random.
            if ($urandom_range(60, 0) == 0) begin
                gaps_on   = !gaps_on;
                stalls_on = 1'($urandom_range(1, 0));
            end
        end
        wait_drained();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        rx_hold   = 0;
        rx_wait   = 0;
        gaps_on   = 1;
        stalls_on = 1;
        // Model reset values.
        hit_total = 0; path_len = 0; load_pos = 0; target_total = 0;
        sig_ok = 0; sig_n = 0; track_flag = 0; gate_flag = 0;
        foreach (src_age[s]) begin
            src_age[s]  = 0;
            src_seen[s] = 0;
        end
        foreach (hit_map[i]) hit_map[i] = 0;
        near_dist = DIST_ALL_ONES;
        near_idx  = 0;
        near_hit  = 0;
        cfg_ratio = 17'd52429;
        cfg_reach = 44'd4000000;
        cfg_age   = 16'd30;
        error_count = 0; items_sent = 0; results_seen = 0; targets_hit = 0;
        commits_sent = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(150);
        set_config(17'd0, REACH_TOP, 16'd1);
        test_random(110);
        set_config(RATIO_FULL, 44'd0, 16'hFFFF);
        test_random(90);
        set_config(17'($urandom_range(65536, 0)), 44'($urandom_range(9000000, 0)),
                   16'($urandom_range(60, 1)));
        test_backpressure();
        test_random(180);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d items, %0d results, %0d path commits, %0d targets in reach.",
                 items_sent, results_seen, commits_sent, targets_hit);
        if (error_count == 0 && pending_status.size() == 0) begin
            $display("nearest_path_point_coverage_core_tb passed");
        end else begin
            $display("nearest_path_point_coverage_core_tb failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #50ms;
        $display("nearest_path_point_coverage_core_tb failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/npc_pkg.sv
rtl/npc_ram.sv
rtl/npc_front.sv
rtl/npc_back.sv
rtl/nearest_path_point_coverage_core.sv
tb/sv/nearest_path_point_coverage_core_tb.sv
